// ===== hdl/quadrotor_rk4_dynamics_step_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quadrotor RK4 integrator
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef QUADROTOR_RK4_DYNAMICS_STEP_MACROS_SVH
`define QUADROTOR_RK4_DYNAMICS_STEP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define QRK4_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("qrk4 check failed");
// next-cycle implication
`define QRK4_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("qrk4 check failed");
`else
`define QRK4_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define QRK4_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hdl/qrk4_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrk4_pkg
// Types, constants and fixed-point helpers of the quadrotor RK4 integrator.
// ----------------------------------------------------------------------------
package qrk4_pkg;

  // request and result payloads
  typedef struct packed {
    logic signed [31:0] thrust_pos_x;
    logic signed [31:0] thrust_neg_x;
    logic signed [31:0] thrust_pos_y;
    logic signed [31:0] thrust_neg_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] roll_rate;
    logic signed [31:0] pitch_rate;
    logic signed [31:0] yaw_rate;
  } out_item_t;

  // register indexes
  typedef enum logic [2:0] {
    CFG_TIME_STEP         = 3'd0,
    CFG_INV_MASS          = 3'd1,
    CFG_GRAVITY           = 3'd2,
    CFG_ARM_OVER_INERTIA  = 3'd3,
    CFG_DRAG_OVER_INERTIA = 3'd4,
    CFG_GROUND_LEVEL      = 3'd5,
    CFG_GROUND_STIFFNESS  = 3'd6
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE, ST_PRE, ST_TRIG_LOAD, ST_TRIG_RED, ST_TRIG_FOLD, ST_TRIG_ROT,
    ST_TRIG_STORE, ST_DERIV, ST_UPD, ST_FIN_LOAD, ST_FIN_DIV, ST_FIN_WR, ST_DONE
  } state_e;

  // per-item multiplies
  typedef enum logic [1:0] {PRE_ACC, PRE_ROLL, PRE_PITCH, PRE_YAW} pop_e;

  // per-derivative multiplies
  typedef enum logic [3:0] {
    OP_CRSP, OP_T1_A, OP_T2_A, OP_KX, OP_T1_B, OP_T2_B, OP_KY,
    OP_T1_C, OP_KZ, OP_GPEN, OP_GADD
  } dop_e;

  localparam int NSTATE    = 12;
  localparam int MAX_STEPS = 30;
  localparam int RED_STEPS = 14;
  localparam int DIV_STEPS = 18;

  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
  localparam logic [46:0]        TWO_PI_U    = 47'd6746518852;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Q16.16 product, round half up, saturate
  function automatic logic signed [31:0] rnd16(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd32768) >>> 16;
    return sat32(t);
  endfunction

  // arctangent of 2^-i in Q0.30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      5'd24: r = 30'd64;
      5'd25: r = 30'd32;
      5'd26: r = 30'd16;
      5'd27: r = 30'd8;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/qrk4_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrk4_in_if
// Thrust request channel: valid/ready with one in_item_t payload.
// ----------------------------------------------------------------------------
interface qrk4_in_if import qrk4_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/qrk4_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrk4_out_if
// State result channel: valid/ready with one out_item_t payload.
// ----------------------------------------------------------------------------
interface qrk4_out_if import qrk4_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/quadrotor_rk4_dynamics_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrotor_rk4_dynamics_step
// One RK4 step of a 12-value quadrotor state per thrust request.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : four rotor thrusts (Q16.16). One request = one time step.
//   out_o : the new 12-value state (Q16.16), one result per request.
//   cfg_* : register writes (index, data), only while the block is idle.
// Sequencing: one request is worked through in full before the next is
//   taken: a single 32x32 multiplier, an iterative CORDIC rotator (16
//   steps by default), a 14-step angle reducer and a 2-bit-per-cycle
//   divide-by-three carry all the work under one sequencer. Ground contact
//   adds a penalty term to the vertical derivative. in_i.ready is high
//   only when idle.
// Reset: state clears to zero, registers take their defaults.
// Stall: the result sits in an output register; a new request may start
//   while it waits, and the block holds its next result until it is taken.
// ----------------------------------------------------------------------------
`include "quadrotor_rk4_dynamics_step_macros.svh"

module quadrotor_rk4_dynamics_step import qrk4_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  qrk4_in_if.sink     in_i,
  qrk4_out_if.source  out_o
);

  localparam int CSTEPS = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
  localparam logic [4:0] ROT_LAST = 5'(CSTEPS - 1);
  localparam logic [4:0] RED_LAST = 5'(RED_STEPS - 1);
  localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);
  localparam logic [3:0] EL_LAST  = 4'(NSTATE - 1);

  // control state
  state_e      state_q, state_d;
  pop_e        pop_q;
  dop_e        dop_q;
  logic        ph_q;
  logic [1:0]  ang_q;
  logic [1:0]  stg_q;
  logic [3:0]  el_q;
  logic [4:0]  cnt_q;
  logic        out_valid_q;

  // registers
  logic [16:0]        dt_q;
  logic [30:0]        inv_mass_q, gravity_q, aoi_q, doi_q, gs_q;
  logic signed [31:0] gl_q;

  // held state and working values
  logic signed [31:0] s_q   [NSTATE];
  logic signed [31:0] st_q  [NSTATE];
  logic signed [51:0] accum_q [NSTATE];
  logic signed [31:0] f_q   [4];
  logic signed [31:0] dr_q  [3];
  logic signed [31:0] kv_q  [3];
  logic signed [31:0] sin_q [3];
  logic signed [31:0] cos_q [3];
  logic signed [31:0] acc_q, crsp_q, t1_q, t2_q;
  logic signed [63:0] prod_q, prod_d;
  out_item_t          out_q;

  // angle reducer, CORDIC, divider
  logic [45:0]        red_m_q;
  logic               red_neg_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic               flip_q;
  logic [35:0]        div_mag_q, quo_q;
  logic [1:0]         rem_q;
  logic               div_neg_q;

  logic signed [31:0] mul_a, mul_b, qr, k_sel, ang_sel;
  logic               accept, out_free, gnd;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign gnd      = (st_q[2] < gl_q);
  assign qr       = rnd16(prod_q);
  assign prod_d   = mul_a * mul_b;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // thrust combinations
  logic signed [31:0] fsum, fdiff_roll, fdiff_pitch, fdiff_yaw;
  assign fsum = sat32(64'(f_q[0]) + 64'(f_q[1]) + 64'(f_q[2]) + 64'(f_q[3]));
  assign fdiff_roll  = sat32(64'(f_q[3]) - 64'(f_q[2]));
  assign fdiff_pitch = sat32(64'(f_q[0]) - 64'(f_q[1]));
  assign fdiff_yaw   = sat32(64'(f_q[0]) + 64'(f_q[1]) - 64'(f_q[2]) - 64'(f_q[3]));

  // derivative of the element under update
  always_comb begin
    if (el_q < 4'd6) begin
      k_sel = st_q[el_q + 4'd6];
    end else if (el_q < 4'd9) begin
      k_sel = kv_q[2'(el_q - 4'd6)];
    end else begin
      k_sel = dr_q[2'(el_q - 4'd9)];
    end
  end

  // angle for the trig pass
  always_comb begin
    unique case (ang_q)
      2'd0:    ang_sel = st_q[3];
      2'd1:    ang_sel = st_q[4];
      default: ang_sel = st_q[5];
    endcase
  end

  // angle reduction step
  logic [46:0] red_cmp;
  assign red_cmp = TWO_PI_U << cnt_q;

  // fold into [-pi/2, pi/2]
  logic signed [35:0] r0, r1, r2, zf;
  logic               fl;
  always_comb begin
    r0 = red_neg_q ? -$signed({3'b000, red_m_q[32:0]}) : $signed({3'b000, red_m_q[32:0]});
    r1 = (r0 < 36'sd0) ? r0 + TWO_PI_Q30 : r0;
    r2 = (r1 > PI_Q30) ? r1 - TWO_PI_Q30 : r1;
    fl = 1'b1;
    if (r2 > HALF_PI_Q30) begin
      zf = PI_Q30 - r2;
    end else if (r2 < -HALF_PI_Q30) begin
      zf = -PI_Q30 - r2;
    end else begin
      zf = r2;
      fl = 1'b0;
    end
  end

  // CORDIC step
  logic signed [33:0] dx, dy, at, xf;
  assign dx = y_q >>> cnt_q;
  assign dy = x_q >>> cnt_q;
  assign at = $signed({4'b0000, atan_q30(cnt_q)});
  assign xf = flip_q ? -x_q : x_q;

  logic signed [33:0] sin_r, cos_r;
  assign sin_r = (y_q + 34'sd8192) >>> 14;
  assign cos_r = (xf + 34'sd8192) >>> 14;

  // stage update values
  logic signed [63:0] p_r17, p_r16;
  logic signed [51:0] p52;
  assign p_r17 = (prod_q + 64'sd65536) >>> 17;
  assign p_r16 = (prod_q + 64'sd32768) >>> 16;
  assign p52   = $signed(prod_q[51:0]);

  // final scaling, divide by three two bits at a time
  logic signed [52:0] fin_sum;
  logic signed [35:0] fin_w;
  logic [3:0]         dv_val;
  logic [1:0]         dv_q, dv_rem;
  logic signed [37:0] fin_qx, fin_inc;
  always_comb begin
    fin_sum = 53'(accum_q[el_q]) + 53'sd196608;
    fin_w   = $signed(fin_sum[52:17]);
    dv_val  = {rem_q, div_mag_q[35:34]};
    if (dv_val >= 4'd9) begin
      dv_q = 2'd3;
    end else if (dv_val >= 4'd6) begin
      dv_q = 2'd2;
    end else if (dv_val >= 4'd3) begin
      dv_q = 2'd1;
    end else begin
      dv_q = 2'd0;
    end
    dv_rem  = 2'(dv_val - (4'(dv_q) << 1) - 4'(dv_q));
    // negative values round the magnitude up so the result floors
    fin_qx  = $signed({2'b00, quo_q}) + 38'(div_neg_q && (rem_q != 2'd0));
    fin_inc = div_neg_q ? -fin_qx : fin_qx;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:       if (in_i.valid) state_d = ST_PRE;
      ST_PRE:        if (ph_q && pop_q == PRE_YAW) state_d = ST_TRIG_LOAD;
      ST_TRIG_LOAD:  state_d = ST_TRIG_RED;
      ST_TRIG_RED:   if (cnt_q == 5'd0) state_d = ST_TRIG_FOLD;
      ST_TRIG_FOLD:  state_d = ST_TRIG_ROT;
      ST_TRIG_ROT:   if (cnt_q == ROT_LAST) state_d = ST_TRIG_STORE;
      ST_TRIG_STORE: state_d = (ang_q == 2'd2) ? ST_DERIV : ST_TRIG_LOAD;
      ST_DERIV: begin
        if (ph_q && ((dop_q == OP_KZ && !gnd) || dop_q == OP_GADD)) state_d = ST_UPD;
      end
      ST_UPD: begin
        if (ph_q && el_q == EL_LAST) begin
          state_d = (stg_q == 2'd3) ? ST_FIN_LOAD : ST_TRIG_LOAD;
        end
      end
      ST_FIN_LOAD:   state_d = ST_FIN_DIV;
      ST_FIN_DIV:    if (cnt_q == DIV_LAST) state_d = ST_FIN_WR;
      ST_FIN_WR:     state_d = (el_q == EL_LAST) ? ST_DONE : ST_FIN_LOAD;
      ST_DONE:       if (out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // outputs: handshake and multiplier operands
  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_PRE: begin
        unique case (pop_q)
          PRE_ACC:   begin mul_a = fsum;                 mul_b = $signed({1'b0, inv_mass_q}); end
          PRE_ROLL:  begin mul_a = $signed({1'b0, aoi_q}); mul_b = fdiff_roll;  end
          PRE_PITCH: begin mul_a = $signed({1'b0, aoi_q}); mul_b = fdiff_pitch; end
          default:   begin mul_a = $signed({1'b0, doi_q}); mul_b = fdiff_yaw;   end
        endcase
      end
      ST_DERIV: begin
        unique case (dop_q)
          OP_CRSP: begin mul_a = cos_q[0]; mul_b = sin_q[1]; end
          OP_T1_A: begin mul_a = crsp_q;   mul_b = cos_q[2]; end
          OP_T2_A: begin mul_a = sin_q[0]; mul_b = sin_q[2]; end
          OP_KX:   begin mul_a = acc_q;    mul_b = sat32(64'(t1_q) + 64'(t2_q)); end
          OP_T1_B: begin mul_a = crsp_q;   mul_b = sin_q[2]; end
          OP_T2_B: begin mul_a = sin_q[0]; mul_b = cos_q[2]; end
          OP_KY:   begin mul_a = acc_q;    mul_b = sat32(64'(t1_q) - 64'(t2_q)); end
          OP_T1_C: begin mul_a = cos_q[0]; mul_b = cos_q[1]; end
          OP_KZ:   begin mul_a = acc_q;    mul_b = t1_q; end
          OP_GPEN: begin
            mul_a = $signed({1'b0, gs_q});
            mul_b = sat32(64'(gl_q) - 64'(st_q[2]));
          end
          OP_GADD: begin mul_a = t1_q; mul_b = $signed({1'b0, inv_mass_q}); end
          default: ;
        endcase
      end
      ST_UPD: begin
        mul_a = k_sel;
        mul_b = $signed({15'd0, dt_q});
      end
      default: ;
    endcase
  end

  // control registers, config and held state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pop_q       <= PRE_ACC;
      dop_q       <= OP_CRSP;
      ph_q        <= 1'b0;
      ang_q       <= 2'd0;
      stg_q       <= 2'd0;
      el_q        <= 4'd0;
      cnt_q       <= 5'd0;
      out_valid_q <= 1'b0;
      dt_q        <= 17'd655;
      inv_mass_q  <= 31'd65536;
      gravity_q   <= 31'd642908;
      aoi_q       <= '0;
      doi_q       <= '0;
      gl_q        <= '0;
      gs_q        <= '0;
      for (int i = 0; i < NSTATE; i++) s_q[i] <= '0;
    end else begin
      state_q <= state_d;

      // register writes
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_TIME_STEP:         dt_q       <= cfg_data_i[16:0];
          CFG_INV_MASS:          inv_mass_q <= cfg_data_i[30:0];
          CFG_GRAVITY:           gravity_q  <= cfg_data_i[30:0];
          CFG_ARM_OVER_INERTIA:  aoi_q      <= cfg_data_i[30:0];
          CFG_DRAG_OVER_INERTIA: doi_q      <= cfg_data_i[30:0];
          CFG_GROUND_LEVEL:      gl_q       <= $signed(cfg_data_i);
          CFG_GROUND_STIFFNESS:  gs_q       <= cfg_data_i[30:0];
          default: ;
        endcase
      end

      // result register valid
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      // sequencer counters
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            pop_q <= PRE_ACC;
            ph_q  <= 1'b0;
          end
        end
        ST_PRE: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (pop_q == PRE_YAW) begin
              ang_q <= 2'd0;
              stg_q <= 2'd0;
            end else begin
              pop_q <= pop_e'(pop_q + 2'd1);
            end
          end
        end
        ST_TRIG_LOAD: cnt_q <= RED_LAST;
        ST_TRIG_RED:  if (cnt_q != 5'd0) cnt_q <= cnt_q - 5'd1;
        ST_TRIG_FOLD: cnt_q <= 5'd0;
        ST_TRIG_ROT:  if (cnt_q != ROT_LAST) cnt_q <= cnt_q + 5'd1;
        ST_TRIG_STORE: begin
          if (ang_q == 2'd2) begin
            dop_q <= OP_CRSP;
            ph_q  <= 1'b0;
          end else begin
            ang_q <= ang_q + 2'd1;
          end
        end
        ST_DERIV: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if ((dop_q == OP_KZ && !gnd) || dop_q == OP_GADD) begin
              el_q <= 4'd0;
            end else begin
              dop_q <= dop_e'(dop_q + 4'd1);
            end
          end
        end
        ST_UPD: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (el_q == EL_LAST) begin
              el_q <= 4'd0;
              if (stg_q != 2'd3) begin
                stg_q <= stg_q + 2'd1;
                ang_q <= 2'd0;
              end
            end else begin
              el_q <= el_q + 4'd1;
            end
          end
        end
        ST_FIN_LOAD: cnt_q <= 5'd0;
        ST_FIN_DIV:  if (cnt_q != DIV_LAST) cnt_q <= cnt_q + 5'd1;
        ST_FIN_WR: begin
          s_q[el_q] <= sat32(64'(s_q[el_q]) + 64'(fin_inc));
          el_q      <= (el_q == EL_LAST) ? 4'd0 : el_q + 4'd1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          f_q[0] <= in_i.payload.thrust_pos_x;
          f_q[1] <= in_i.payload.thrust_neg_x;
          f_q[2] <= in_i.payload.thrust_pos_y;
          f_q[3] <= in_i.payload.thrust_neg_y;
          for (int i = 0; i < NSTATE; i++) st_q[i] <= s_q[i];
        end
      end
      ST_PRE: begin
        if (ph_q) begin
          unique case (pop_q)
            PRE_ACC:   acc_q   <= qr;
            PRE_ROLL:  dr_q[0] <= qr;
            PRE_PITCH: dr_q[1] <= qr;
            default:   dr_q[2] <= qr;
          endcase
        end
      end
      ST_TRIG_LOAD: begin
        red_m_q   <= {(ang_sel < 32'sd0) ? 32'(-ang_sel) : 32'(ang_sel), 14'd0};
        red_neg_q <= (ang_sel < 32'sd0);
      end
      ST_TRIG_RED: begin
        if ({1'b0, red_m_q} >= red_cmp) red_m_q <= 46'({1'b0, red_m_q} - red_cmp);
      end
      ST_TRIG_FOLD: begin
        z_q    <= 34'(zf);
        x_q    <= GAIN_Q30;
        y_q    <= '0;
        flip_q <= fl;
      end
      ST_TRIG_ROT: begin
        if (z_q >= 34'sd0) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + at;
        end
      end
      ST_TRIG_STORE: begin
        sin_q[ang_q] <= 32'(sin_r);
        cos_q[ang_q] <= 32'(cos_r);
      end
      ST_DERIV: begin
        if (ph_q) begin
          unique case (dop_q)
            OP_CRSP: crsp_q  <= qr;
            OP_T1_A: t1_q    <= qr;
            OP_T2_A: t2_q    <= qr;
            OP_KX:   kv_q[0] <= qr;
            OP_T1_B: t1_q    <= qr;
            OP_T2_B: t2_q    <= qr;
            OP_KY:   kv_q[1] <= qr;
            OP_T1_C: t1_q    <= qr;
            OP_KZ:   kv_q[2] <= sat32(64'(qr) - 64'(gravity_q));
            OP_GPEN: t1_q    <= qr;
            OP_GADD: kv_q[2] <= sat32(64'(kv_q[2]) + 64'(qr));
            default: ;
          endcase
        end
      end
      ST_UPD: begin
        if (ph_q) begin
          unique case (stg_q)
            2'd0: begin
              st_q[el_q]    <= sat32(64'(s_q[el_q]) + p_r17);
              accum_q[el_q] <= p52;
            end
            2'd1: begin
              st_q[el_q]    <= sat32(64'(s_q[el_q]) + p_r17);
              accum_q[el_q] <= accum_q[el_q] + (p52 <<< 1);
            end
            2'd2: begin
              st_q[el_q]    <= sat32(64'(s_q[el_q]) + p_r16);
              accum_q[el_q] <= accum_q[el_q] + (p52 <<< 1);
            end
            default: accum_q[el_q] <= accum_q[el_q] + p52;
          endcase
        end
      end
      ST_FIN_LOAD: begin
        div_mag_q <= (fin_w < 36'sd0) ? 36'(-fin_w) : 36'(fin_w);
        div_neg_q <= (fin_w < 36'sd0);
        rem_q     <= 2'd0;
        quo_q     <= '0;
      end
      ST_FIN_DIV: begin
        rem_q     <= dv_rem;
        quo_q     <= {quo_q[33:0], dv_q};
        div_mag_q <= {div_mag_q[33:0], 2'b00};
      end
      ST_DONE: begin
        if (out_free) begin
          out_q.pos_x      <= s_q[0];
          out_q.pos_y      <= s_q[1];
          out_q.pos_z      <= s_q[2];
          out_q.roll       <= s_q[3];
          out_q.pitch      <= s_q[4];
          out_q.yaw        <= s_q[5];
          out_q.vel_x      <= s_q[6];
          out_q.vel_y      <= s_q[7];
          out_q.vel_z      <= s_q[8];
          out_q.roll_rate  <= s_q[9];
          out_q.pitch_rate <= s_q[10];
          out_q.yaw_rate   <= s_q[11];
        end
      end
      default: ;
    endcase
  end

  // checks
  `QRK4_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, (in_i.valid && in_i.ready), (state_q == ST_PRE))
  `QRK4_ASSERT_NEXT(a_done_loads, clk_i, rst_ni, (state_q == ST_DONE && out_free), out_valid_q)
  `QRK4_ASSERT_NOW(a_valid_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == ST_DONE))

endmodule
